// ===== rtl/core/vfc_pkg.sv =====
// shared types, codes and defaults of the voxel visible face culler
package vfc_pkg;

	localparam int DEF_CHUNK_SIDE  = 16;
	localparam int DEF_CHUNK_TALL  = 256;
	localparam int DEF_TYPE_BITS   = 8;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int FACE_NUM_W = 19;
	localparam int NUM_DIRS   = 6;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_EXAMINE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [2:0] DIR_NEG_X = 3'd0;
	localparam logic [2:0] DIR_POS_X = 3'd1;
	localparam logic [2:0] DIR_NEG_Y = 3'd2;
	localparam logic [2:0] DIR_POS_Y = 3'd3;
	localparam logic [2:0] DIR_NEG_Z = 3'd4;
	localparam logic [2:0] DIR_POS_Z = 3'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] cell_x;
		logic [7:0] cell_y;
		logic [3:0] cell_z;
		logic [7:0] voxel_type;
	} in_item_t;

	typedef struct packed {
		logic                  has_face;
		logic [2:0]            face_dir;
		logic [FACE_NUM_W-1:0] face_number;
		logic [7:0]            face_type;
		logic [3:0]            out_x;
		logic [7:0]            out_y;
		logic [3:0]            out_z;
		logic                  last_of_cell;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_EXAMINE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                in_chunk;
		logic [3:0]          cell_x;
		logic [7:0]          cell_y;
		logic [3:0]          cell_z;
		logic [7:0]          voxel_type;
		logic [NUM_DIRS-1:0] nbr_in;
	} dec_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} back_state_t;

endpackage

// ===== rtl/core/vfc_chan_if.sv =====
// valid/ready channel carrying one payload item per transfer
interface vfc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vfc_ram.sv =====
// generic ram, one write port and two registered read ports
module vfc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/core/vfc_queue.sv =====
// short first-in first-out queue between front and back
module vfc_queue #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	item_t         entry_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/vfc_front.sv =====
// front end: accepts commands, checks bounds and neighbours, queues known ones
module vfc_front #(
	parameter int CHUNK_SIDE = vfc_pkg::DEF_CHUNK_SIDE,
	parameter int CHUNK_TALL = vfc_pkg::DEF_CHUNK_TALL
) (
	vfc_chan_if.sink      items,
	input  logic          clearing,
	output logic          push_valid,
	input  logic          push_ready,
	output vfc_pkg::dec_t push_data
);

	int            xi;
	int            yi;
	int            zi;
	logic          known_cmd;
	vfc_pkg::op_t  op;

	assign xi = int'(items.data.cell_x);
	assign yi = int'(items.data.cell_y);
	assign zi = int'(items.data.cell_z);

	assign items.ready = !clearing && push_ready;
	assign push_valid  = items.valid && !clearing && known_cmd;

	always_comb begin
		known_cmd = 1'b1;
		op        = vfc_pkg::OP_WRITE;
		case (items.data.command)
			vfc_pkg::CMD_WRITE:   op = vfc_pkg::OP_WRITE;
			vfc_pkg::CMD_EXAMINE: op = vfc_pkg::OP_EXAMINE;
			vfc_pkg::CMD_CLEAR:   op = vfc_pkg::OP_CLEAR;
			default:              known_cmd = 1'b0;
		endcase
	end

	always_comb begin
		push_data.op         = op;
		push_data.in_chunk   = (xi < CHUNK_SIDE) && (yi < CHUNK_TALL) && (zi < CHUNK_SIDE);
		push_data.cell_x     = items.data.cell_x;
		push_data.cell_y     = items.data.cell_y;
		push_data.cell_z     = items.data.cell_z;
		push_data.voxel_type = items.data.voxel_type;
		push_data.nbr_in[0]  = (xi != 0);
		push_data.nbr_in[1]  = (xi < CHUNK_SIDE - 1);
		push_data.nbr_in[2]  = (yi != 0);
		push_data.nbr_in[3]  = (yi < CHUNK_TALL - 1);
		push_data.nbr_in[4]  = (zi != 0);
		push_data.nbr_in[5]  = (zi < CHUNK_SIDE - 1);
	end

endmodule

// ===== rtl/core/vfc_back.sv =====
// back end: voxel store, neighbour reads, face emission and face counter
module vfc_back #(
	parameter int CHUNK_SIDE = vfc_pkg::DEF_CHUNK_SIDE,
	parameter int CHUNK_TALL = vfc_pkg::DEF_CHUNK_TALL,
	parameter int TYPE_BITS  = vfc_pkg::DEF_TYPE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    air_code,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  vfc_pkg::dec_t pop_data,
	output logic          clearing,
	vfc_chan_if.source    faces
);

	localparam int XB     = $clog2(CHUNK_SIDE);
	localparam int YB     = $clog2(CHUNK_TALL);
	localparam int ZB     = XB;
	localparam int AW     = XB + YB + ZB;
	localparam int DEPTH  = 1 << AW;
	localparam int WORD_W = TYPE_BITS + 1;
	localparam int NW     = vfc_pkg::FACE_NUM_W;
	localparam longint FACE_ALL =
		longint'(CHUNK_SIDE) * longint'(CHUNK_SIDE) * longint'(CHUNK_TALL) * 6 - 1;
	localparam longint COUNTER_TOP = (longint'(1) << NW) - 1;
	localparam logic [NW-1:0] FACE_MAX =
		(FACE_ALL < COUNTER_TOP) ? NW'(FACE_ALL) : NW'(COUNTER_TOP);
	localparam logic [2:0] SLOT_CELL  = 3'd0;
	localparam logic [2:0] SLOT_NEG_X = 3'd1;
	localparam logic [2:0] SLOT_POS_X = 3'd2;
	localparam logic [2:0] SLOT_NEG_Y = 3'd3;
	localparam logic [2:0] SLOT_POS_Y = 3'd4;
	localparam logic [2:0] SLOT_NEG_Z = 3'd5;
	localparam logic [2:0] SLOT_POS_Z = 3'd6;
	localparam logic [2:0] LAST_ISSUE = 3'd4;
	localparam logic [1:0] LAST_PAIR  = 2'd3;

	vfc_pkg::back_state_t st_q;
	vfc_pkg::back_state_t st_d;

	logic [AW-1:0]             clr_cnt_q;
	vfc_pkg::dec_t             cur_q;
	logic                      cell_air_q;
	logic [TYPE_BITS-1:0]      cell_type_q;
	logic [vfc_pkg::NUM_DIRS-1:0] nbr_air_q;
	logic [vfc_pkg::NUM_DIRS-1:0] done_q;
	logic [2:0]                issue_q;
	logic                      rd_vld_s1;
	logic [1:0]                rd_pair_s1;
	logic [NW-1:0]             count_q;
	logic                      out_valid_q;
	vfc_pkg::out_item_t        out_q;

	logic                      we;
	logic [AW-1:0]             waddr;
	logic [WORD_W-1:0]         wdata;
	logic                      issue;
	logic [AW-1:0]             raddr_a;
	logic [AW-1:0]             raddr_b;
	logic [WORD_W-1:0]         rdata_a;
	logic [WORD_W-1:0]         rdata_b;
	logic [TYPE_BITS-1:0]      air_t;
	logic                      air_a;
	logic                      air_b;
	logic [2:0]                nbr_idx_a;
	logic [2:0]                nbr_idx_b;
	logic [vfc_pkg::NUM_DIRS-1:0] nbr_air_d;
	logic [vfc_pkg::NUM_DIRS-1:0] vis;
	logic [vfc_pkg::NUM_DIRS-1:0] rem;
	logic [vfc_pkg::NUM_DIRS-1:0] pick;
	logic [2:0]                pick_dir;
	logic                      out_free;
	logic                      emit;
	logic                      cnt_clr;
	logic                      cnt_inc;
	vfc_pkg::out_item_t        emit_item;

	function automatic logic [AW-1:0] slot_addr(input vfc_pkg::dec_t d, input logic [2:0] slot);
		logic [XB-1:0] xs;
		logic [YB-1:0] ys;
		logic [ZB-1:0] zs;
		xs = XB'(d.cell_x);
		ys = YB'(d.cell_y);
		zs = ZB'(d.cell_z);
		case (slot)
			SLOT_NEG_X: xs = xs - 1'b1;
			SLOT_POS_X: xs = xs + 1'b1;
			SLOT_NEG_Y: ys = ys - 1'b1;
			SLOT_POS_Y: ys = ys + 1'b1;
			SLOT_NEG_Z: zs = zs - 1'b1;
			SLOT_POS_Z: zs = zs + 1'b1;
			default: ;
		endcase
		return {xs, ys, zs};
	endfunction

	vfc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (issue),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.re_b    (issue),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign clearing = (st_q == vfc_pkg::ST_CLEAR);
	assign air_t    = TYPE_BITS'(air_code);
	assign raddr_a  = slot_addr(cur_q, {issue_q[1:0], 1'b0});
	assign raddr_b  = slot_addr(cur_q, {issue_q[1:0], 1'b1});
	// unwritten cells read as air
	assign air_a    = !rdata_a[TYPE_BITS] || (rdata_a[TYPE_BITS-1:0] == air_t);
	assign air_b    = !rdata_b[TYPE_BITS] || (rdata_b[TYPE_BITS-1:0] == air_t);
	assign nbr_idx_a = {rd_pair_s1, 1'b0} - 3'd1;
	assign nbr_idx_b = {rd_pair_s1, 1'b0};

	always_comb begin
		nbr_air_d = nbr_air_q;
		if (rd_pair_s1 != 2'd0) begin
			nbr_air_d[nbr_idx_a] = air_a;
		end
		if (rd_pair_s1 != LAST_PAIR) begin
			nbr_air_d[nbr_idx_b] = air_b;
		end
	end

	assign vis  = cell_air_q ? '0 : (nbr_air_q | ~cur_q.nbr_in);
	assign rem  = vis & ~done_q;
	assign pick = rem & (~rem + 1'b1);

	always_comb begin
		pick_dir = vfc_pkg::DIR_NEG_X;
		for (int i = 0; i < vfc_pkg::NUM_DIRS; i++) begin
			if (pick[i]) begin
				pick_dir = 3'(i);
			end
		end
	end

	assign out_free    = !out_valid_q || faces.ready;
	assign faces.valid = out_valid_q;
	assign faces.data  = out_q;

	always_comb begin
		st_d      = st_q;
		pop_ready = 1'b0;
		we        = 1'b0;
		waddr     = clr_cnt_q;
		wdata     = '0;
		issue     = 1'b0;
		emit      = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		emit_item              = '0;
		emit_item.face_dir     = vfc_pkg::DIR_NEG_X;
		emit_item.out_x        = cur_q.cell_x;
		emit_item.out_y        = cur_q.cell_y;
		emit_item.out_z        = cur_q.cell_z;
		case (st_q)
			vfc_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (clr_cnt_q == '1) begin
					st_d = vfc_pkg::ST_IDLE;
				end
			end
			vfc_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					case (pop_data.op)
						vfc_pkg::OP_WRITE: begin
							we    = pop_data.in_chunk;
							waddr = slot_addr(pop_data, SLOT_CELL);
							wdata = {1'b1, TYPE_BITS'(pop_data.voxel_type)};
						end
						vfc_pkg::OP_CLEAR: cnt_clr = 1'b1;
						vfc_pkg::OP_EXAMINE: begin
							st_d = pop_data.in_chunk ? vfc_pkg::ST_READ : vfc_pkg::ST_EMIT;
						end
						default: ;
					endcase
				end
			end
			vfc_pkg::ST_READ: begin
				issue = (issue_q != LAST_ISSUE);
				if (rd_vld_s1 && (rd_pair_s1 == LAST_PAIR)) begin
					st_d = vfc_pkg::ST_EMIT;
				end
			end
			vfc_pkg::ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (rem == '0) begin
						emit_item.last_of_cell = 1'b1;
						st_d = vfc_pkg::ST_IDLE;
					end else begin
						cnt_inc                = 1'b1;
						emit_item.has_face     = 1'b1;
						emit_item.face_dir     = pick_dir;
						emit_item.face_number  = count_q;
						emit_item.face_type    = 8'(cell_type_q);
						emit_item.last_of_cell = ((rem & ~pick) == '0);
						if (emit_item.last_of_cell) begin
							st_d = vfc_pkg::ST_IDLE;
						end
					end
				end
			end
			default: st_d = vfc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= vfc_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= issue;
			if (st_q == vfc_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (pop_ready && pop_valid) begin
				issue_q <= '0;
				done_q  <= '0;
			end else begin
				if (issue) begin
					issue_q <= issue_q + 3'd1;
				end
				if (emit) begin
					done_q <= done_q | pick;
				end
			end
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc && (count_q < FACE_MAX)) begin
				count_q <= count_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (faces.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_pair_s1 <= issue_q[1:0];
		if (pop_ready && pop_valid) begin
			cur_q      <= pop_data;
			cell_air_q <= 1'b1;
		end
		if (rd_vld_s1) begin
			if (rd_pair_s1 == 2'd0) begin
				cell_air_q  <= air_a;
				cell_type_q <= rdata_a[TYPE_BITS-1:0];
			end
			nbr_air_q <= nbr_air_d;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

endmodule

// ===== rtl/core/voxel_visible_face_culler_core.sv =====
// top level of the voxel visible face culler
//
// items: command channel (write voxel, examine cell, clear face counter).
// faces: result channel; an examine gives one item per visible face in the
//   order -x, +x, -y, +y, -z, +z, or one null item when no face shows.
// cfg_we / cfg_wdata: sets the air code; it must be written by the user only
//   while the block is idle; the block itself does not enforce this.
// after reset the voxel store is swept to the unwritten state, one cell per
//   cycle; items.ready stays low during the sweep.
// the back end carries out a write or a clear as it takes it from the queue.
//   an examine fetches the cell and its six neighbours over the two read
//   ports of the store (skipped for a cell outside the chunk), then gives its
//   result items in turn, holding while the output register is full.
// a two-entry queue lets new commands transfer while the back end works;
//   a result waits in the output register while faces.ready is low, and the
//   back end holds until it is taken.
module voxel_visible_face_culler_core #(
	parameter int CHUNK_SIDE  = vfc_pkg::DEF_CHUNK_SIDE,
	parameter int CHUNK_TALL  = vfc_pkg::DEF_CHUNK_TALL,
	parameter int TYPE_BITS   = vfc_pkg::DEF_TYPE_BITS,
	parameter int QUEUE_DEPTH = vfc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	vfc_chan_if.sink   items,
	vfc_chan_if.source faces,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic          air_code_q;
	logic [7:0]    air_q;
	logic          clearing;
	logic          push_valid;
	logic          push_ready;
	vfc_pkg::dec_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	vfc_pkg::dec_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q      <= '0;
			air_code_q <= 1'b0;
		end else if (cfg_we) begin
			air_q      <= cfg_wdata;
			air_code_q <= 1'b1;
		end
	end

	vfc_front #(
		.CHUNK_SIDE (CHUNK_SIDE),
		.CHUNK_TALL (CHUNK_TALL)
	) u_front (
		.items      (items),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	vfc_queue #(
		.item_t (vfc_pkg::dec_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	vfc_back #(
		.CHUNK_SIDE (CHUNK_SIDE),
		.CHUNK_TALL (CHUNK_TALL),
		.TYPE_BITS  (TYPE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.air_code  (air_code_q ? air_q : 8'd0),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.clearing  (clearing),
		.faces     (faces)
	);

endmodule

// ===== rtl/core/vfc_checker.sv =====
// port-level checks of the face culler, bound to the top level
module vfc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               faces_valid,
	input logic               faces_ready,
	input vfc_pkg::out_item_t faces_data
);

	logic                           open_q;
	logic [2:0]                     prev_dir_q;
	logic [vfc_pkg::FACE_NUM_W-1:0] prev_num_q;
	logic [3:0]                     prev_x_q;
	logic [7:0]                     prev_y_q;
	logic [3:0]                     prev_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (faces_valid && faces_ready) begin
			open_q <= !faces_data.last_of_cell;
		end
	end

	always_ff @(posedge clk) begin
		if (faces_valid && faces_ready) begin
			prev_dir_q <= faces_data.face_dir;
			prev_num_q <= faces_data.face_number;
			prev_x_q   <= faces_data.out_x;
			prev_y_q   <= faces_data.out_y;
			prev_z_q   <= faces_data.out_z;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		faces_valid && !faces_ready |=> faces_valid && $stable(faces_data))
		else $error("result changed while stalled");

	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		faces_valid && !faces_data.has_face |->
			faces_data.last_of_cell && faces_data.face_dir == vfc_pkg::DIR_NEG_X &&
			faces_data.face_number == '0 && faces_data.face_type == '0)
		else $error("malformed null result");

	a_same_cell: assert property (@(posedge clk) disable iff (!arst_n)
		faces_valid && open_q |->
			faces_data.has_face && faces_data.face_dir > prev_dir_q &&
			faces_data.out_x == prev_x_q && faces_data.out_y == prev_y_q &&
			faces_data.out_z == prev_z_q)
		else $error("faces of one cell out of order");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		faces_valid && open_q |->
			faces_data.face_number == prev_num_q + 1'b1 ||
			faces_data.face_number == prev_num_q)
		else $error("face number skipped");

endmodule

bind voxel_visible_face_culler_core vfc_checker u_vfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.faces_valid (faces.valid),
	.faces_ready (faces.ready),
	.faces_data  (faces.data)
);

// ===== dv/voxel_visible_face_culler_core_tb.sv =====
// testbench of the voxel face culler: directed and random commands checked against a face predictor
module voxel_visible_face_culler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CELL_COUNT =
		vfc_pkg::DEF_CHUNK_SIDE * vfc_pkg::DEF_CHUNK_SIDE * vfc_pkg::DEF_CHUNK_TALL;
	localparam int COUNT_TOP = (1 << vfc_pkg::FACE_NUM_W) - 1;
	localparam int FACE_LIMIT =
		(CELL_COUNT * 6 - 1 < COUNT_TOP) ? CELL_COUNT * 6 - 1 : COUNT_TOP;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PATTERN
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic src_valid = 1'b0;
	vfc_pkg::in_item_t src_data = '0;
	logic sink_ready = 1'b0;

	vfc_chan_if #(.payload_t(vfc_pkg::in_item_t)) items_if ();
	vfc_chan_if #(.payload_t(vfc_pkg::out_item_t)) faces_if ();

	assign items_if.valid = src_valid;
	assign items_if.data = src_data;
	assign faces_if.ready = sink_ready;

	voxel_visible_face_culler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.faces(faces_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// face predictor state
	bit [7:0] cell_type [CELL_COUNT];
	bit cell_set [CELL_COUNT];
	bit [vfc_pkg::FACE_NUM_W-1:0] face_count = '0;
	bit [7:0] air_code_m = 8'h00;
	vfc_pkg::out_item_t pending_faces[$];

	int mismatch_count = 0;
	int burst_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic [7:0] stall_pat = 8'b1011_0110;
	logic [3:0] base_x = '0;
	logic [7:0] base_y = '0;
	logic [3:0] base_z = '0;

	function automatic int cell_slot(int x, int y, int z);
		return (x * vfc_pkg::DEF_CHUNK_TALL + y) * vfc_pkg::DEF_CHUNK_SIDE + z;
	endfunction

	function automatic bit air_at(int x, int y, int z);
		int slot;
		if (x < 0 || x >= vfc_pkg::DEF_CHUNK_SIDE || y < 0 || y >= vfc_pkg::DEF_CHUNK_TALL ||
				z < 0 || z >= vfc_pkg::DEF_CHUNK_SIDE)
			return 1'b1;
		slot = cell_slot(x, y, z);
		if (!cell_set[slot])
			return 1'b1;
		return cell_type[slot] == air_code_m;
	endfunction

	// model update and expected faces of one accepted command
	task automatic predict_faces(input vfc_pkg::in_item_t it);
		int step_x [6] = '{-1, 1, 0, 0, 0, 0};
		int step_y [6] = '{0, 0, -1, 1, 0, 0};
		int step_z [6] = '{0, 0, 0, 0, -1, 1};
		int x, y, z, slot;
		vfc_pkg::out_item_t f;
		vfc_pkg::out_item_t cell_faces[$];
		x = int'(it.cell_x);
		y = int'(it.cell_y);
		z = int'(it.cell_z);
		slot = cell_slot(x, y, z);
		case (it.command)
			vfc_pkg::CMD_WRITE: begin
				cell_type[slot] = it.voxel_type;
				cell_set[slot] = 1'b1;
			end
			vfc_pkg::CMD_CLEAR: face_count = '0;
			vfc_pkg::CMD_EXAMINE: begin
				if (!air_at(x, y, z)) begin
					for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
						if (air_at(x + step_x[d], y + step_y[d], z + step_z[d])) begin
							f = '0;
							f.has_face = 1'b1;
							f.face_dir = 3'(d);
							f.face_number = face_count;
							f.face_type = cell_type[slot];
							f.out_x = it.cell_x;
							f.out_y = it.cell_y;
							f.out_z = it.cell_z;
							cell_faces = {cell_faces, f};
							if (face_count < FACE_LIMIT)
								face_count++;
						end
					end
				end
				if (cell_faces.size() == 0) begin
					f = '0;
					f.out_x = it.cell_x;
					f.out_y = it.cell_y;
					f.out_z = it.cell_z;
					cell_faces = {cell_faces, f};
				end
				cell_faces[cell_faces.size() - 1].last_of_cell = 1'b1;
				pending_faces = {pending_faces, cell_faces};
			end
			default: ;
		endcase
	endtask

	// sender: bursts of random length with random gaps
	task automatic send_item(input vfc_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				src_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		src_valid <= 1'b1;
		src_data <= it;
		do @(posedge clk); while (!items_if.ready);
		predict_faces(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		src_valid <= 1'b0;
		while (pending_faces.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_air_code(input logic [7:0] code);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(negedge clk);
		cfg_we <= 1'b0;
		air_code_m = code;
	endtask

	function automatic vfc_pkg::in_item_t make_item(logic [1:0] cmd, int x, int y, int z,
			int vt);
		vfc_pkg::in_item_t it;
		it.command = cmd;
		it.cell_x = 4'(x);
		it.cell_y = 8'(y);
		it.cell_z = 4'(z);
		it.voxel_type = 8'(vt);
		return it;
	endfunction

	function automatic vfc_pkg::in_item_t random_command();
		vfc_pkg::in_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			it.command = vfc_pkg::CMD_WRITE;
		else if (pick < 93)
			it.command = vfc_pkg::CMD_EXAMINE;
		else if (pick < 97)
			it.command = vfc_pkg::CMD_CLEAR;
		else
			it.command = CMD_UNUSED;
		if ($urandom_range(0, 3) == 0) begin
			it.cell_x = 4'($urandom);
			it.cell_y = 8'($urandom);
			it.cell_z = 4'($urandom);
		end else begin
			it.cell_x = base_x + 4'($urandom_range(0, 3));
			it.cell_y = base_y + 8'($urandom_range(0, 3));
			it.cell_z = base_z + 4'($urandom_range(0, 3));
		end
		it.voxel_type = ($urandom_range(0, 3) == 0) ? air_code_m : 8'($urandom);
		return it;
	endfunction

	// small neighborhood so that writes and examines meet
	task automatic pick_cluster();
		base_x = 4'($urandom);
		base_y = ($urandom_range(0, 4) == 0) ? 8'hfd : 8'($urandom);
		base_z = 4'($urandom);
	endtask

	task automatic test_corner_cells();
		send_item(make_item(vfc_pkg::CMD_WRITE, 0, 0, 0, 255));
		send_item(make_item(vfc_pkg::CMD_WRITE, 15, 255, 15, 1));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 0, 0, 0, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 15, 255, 15, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 7, 128, 7, 0));
		send_item(make_item(CMD_UNUSED, 15, 255, 15, 255));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 15, 255, 15, 0));
	endtask

	task automatic test_occlusion();
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 10, 5, 8'h5a));
		send_item(make_item(vfc_pkg::CMD_WRITE, 4, 10, 5, 8'h11));
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 11, 5, 8'h22));
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 10, 6, 8'h33));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 5, 10, 5, 0));
		send_item(make_item(vfc_pkg::CMD_WRITE, 6, 10, 5, 8'h44));
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 9, 5, 8'h44));
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 10, 4, 8'h44));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 5, 10, 5, 0));
		// neighbor back to air exposes one face
		send_item(make_item(vfc_pkg::CMD_WRITE, 5, 11, 5, 8'h00));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 5, 10, 5, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 4, 10, 5, 0));
	endtask

	task automatic test_counter_clear();
		send_item(make_item(vfc_pkg::CMD_CLEAR, 0, 0, 0, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 0, 0, 0, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 4, 10, 5, 0));
	endtask

	task automatic test_air_code_change();
		set_air_code(8'hff);
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 0, 0, 0, 0));
		send_item(make_item(vfc_pkg::CMD_WRITE, 3, 3, 3, 0));
		send_item(make_item(vfc_pkg::CMD_EXAMINE, 3, 3, 3, 0));
	endtask

	task automatic test_random_traffic(input int count, input logic [7:0] air,
			input sink_mode_t mode);
		vfc_pkg::in_item_t it;
		int sent;
		set_air_code(air);
		sink_mode = mode;
		pick_cluster();
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 39) == 0)
				pick_cluster();
			it = random_command();
			send_item(it);
			if (it.command != CMD_UNUSED)
				sent++;
		end
	endtask

	// long receiver hold while examines keep coming
	task automatic test_backpressure();
		drain_results();
		sink_mode = SINK_OPEN;
		hold_reqs++;
		burst_left = 40;
		repeat (30)
			send_item(make_item(vfc_pkg::CMD_EXAMINE, base_x + 4'($urandom_range(0, 3)),
				base_y + 8'($urandom_range(0, 3)), base_z + 4'($urandom_range(0, 3)), 0));
		sink_mode = SINK_RANDOM;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		stall_pat <= {stall_pat[0], stall_pat[7:1]};
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			sink_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			sink_ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: sink_ready <= 1'b1;
				SINK_RANDOM: sink_ready <= ($urandom_range(0, 99) >= 30);
				default: sink_ready <= stall_pat[0];
			endcase
		end
	end

	task automatic report_face(input string what, input vfc_pkg::out_item_t want,
			input vfc_pkg::out_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s at %0t: expected face %0b dir %0d num %0d type %0h xyz %0d,%0d,%0d last %0b",
				what, $realtime, want.has_face, want.face_dir, want.face_number, want.face_type,
				want.out_x, want.out_y, want.out_z, want.last_of_cell);
			$display("  actual face %0b dir %0d num %0d type %0h xyz %0d,%0d,%0d last %0b",
				got.has_face, got.face_dir, got.face_number, got.face_type,
				got.out_x, got.out_y, got.out_z, got.last_of_cell);
		end
	endtask

	// face checker
	always @(posedge clk) begin
		vfc_pkg::out_item_t want;
		vfc_pkg::out_item_t got;
		if (arst_n && faces_if.valid && faces_if.ready) begin
			got = faces_if.data;
			if (pending_faces.size() == 0) begin
				report_face("unexpected face transfer", '0, got);
			end else begin
				want = pending_faces.pop_front();
				if (got.has_face !== want.has_face || got.face_dir !== want.face_dir ||
						got.face_number !== want.face_number ||
						got.face_type !== want.face_type || got.out_x !== want.out_x ||
						got.out_y !== want.out_y || got.out_z !== want.out_z ||
						got.last_of_cell !== want.last_of_cell)
					report_face("face mismatch", want, got);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// store sweep after reset
		do @(posedge clk); while (!items_if.ready);
		set_air_code(8'h00);
		test_corner_cells();
		test_occlusion();
		test_counter_clear();
		test_air_code_change();
		test_random_traffic(140, 8'h00, SINK_RANDOM);
		test_backpressure();
		test_random_traffic(100, 8'hff, SINK_PATTERN);
		test_random_traffic(90, 8'($urandom_range(1, 254)), SINK_OPEN);
		test_random_traffic(70, 8'h00, SINK_RANDOM);
		drain_results();
		if (mismatch_count == 0 && pending_faces.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
